### hw/rtl/one_wire_bus_master_assert.svh
// ----------------------------------------------------------------------------
// one_wire_bus_master assertion macros
// shared property forms for the one-wire master checks
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_BUS_MASTER_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_ASSERT_SVH

// same-cycle implication
`define OWBM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OWBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg
// types and constants of the one-wire bus master
// ----------------------------------------------------------------------------
package owbm_pkg;

  localparam int unsigned TIME_W   = 10;
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);

  typedef enum logic [2:0] {
    K_TICK  = 3'd0,
    K_RESET = 3'd1,
    K_WBIT  = 3'd2,
    K_RBIT  = 3'd3,
    K_WBYTE = 3'd4,
    K_RBYTE = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_TAIL = 4'd3,
    PH_SLOT_LOW = 4'd4,
    PH_W1_TAIL  = 4'd5,
    PH_W0_LOW   = 4'd6,
    PH_RD_WAIT  = 4'd7,
    PH_RD_TAIL  = 4'd8
  } phase_t;

  localparam logic [REG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SHORT_LOW     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WRITE_ONE_TAIL = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_WRITE_ZERO_LOW = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_READ_TAIL     = 3'd7;

  typedef logic [TIME_W-1:0] time_us_t;

  localparam time_us_t REG_DEFAULTS [NUM_REGS] = '{
    10'd480, 10'd70, 10'd412, 10'd6, 10'd62, 10'd70, 10'd9, 10'd60
  };

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_in;
    logic       line_level;
  } owbm_in_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] data_out;
    logic       rejected;
  } owbm_out_t;

endpackage

### hw/rtl/one_wire_bus_master.sv
// one-wire bus master: the result is registered in the cycle after the input
// transfer; throughput one item per cycle unless out_ready stalls the output; the
// state update is a single counter compare and phase step done within the accepting cycle
// rst_n (synchronous, active low) returns idle state, drops any waiting
// result and loads the timing registers with their defaults
// ----------------------------------------------------------------------------
// one_wire_bus_master
// open-drain 1-wire master with configurable reset, write and read slots
// ----------------------------------------------------------------------------
module one_wire_bus_master (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  owbm_pkg::owbm_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output owbm_pkg::owbm_out_t               out_data,
  input  logic                              cfg_we,
  input  logic [owbm_pkg::REG_IDX_W-1:0]    cfg_addr,
  input  logic [owbm_pkg::TIME_W-1:0]       cfg_wdata
);
  import owbm_pkg::*;

  `include "one_wire_bus_master_assert.svh"

  time_us_t   cfg_regs_r [NUM_REGS];
  phase_t     phase_r, phase_nxt;
  time_us_t   us_counter_r, us_counter_nxt;
  logic [3:0] bits_left_r, bits_left_nxt;
  logic [7:0] shift_data_r, shift_data_nxt;
  logic [2:0] active_cmd_r, active_cmd_nxt;
  owbm_out_t  out_r, out_nxt;
  logic       out_valid_r;

  logic       in_fire;
  logic       is_write;
  logic       new_write;
  time_us_t   phase_len;
  time_us_t   cnt_inc;
  logic [7:0] shift_after;
  logic       done;
  logic       rej;
  logic [7:0] result;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // timing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_regs_r <= REG_DEFAULTS;
    end else if (cfg_we) begin
      cfg_regs_r[cfg_addr] <= cfg_wdata;
    end
  end

  always_comb begin
    case (phase_r)
      PH_RST_LOW:  phase_len = cfg_regs_r[REG_RESET_LOW];
      PH_RST_WAIT: phase_len = cfg_regs_r[REG_PRESENCE_WAIT];
      PH_RST_TAIL: phase_len = cfg_regs_r[REG_RESET_TAIL];
      PH_SLOT_LOW: phase_len = cfg_regs_r[REG_SHORT_LOW];
      PH_W1_TAIL:  phase_len = cfg_regs_r[REG_WRITE_ONE_TAIL];
      PH_W0_LOW:   phase_len = cfg_regs_r[REG_WRITE_ZERO_LOW];
      PH_RD_WAIT:  phase_len = cfg_regs_r[REG_READ_SAMPLE];
      PH_RD_TAIL:  phase_len = cfg_regs_r[REG_READ_TAIL];
      default:     phase_len = '0;
    endcase
  end

  assign is_write    = (active_cmd_r == K_WBIT) || (active_cmd_r == K_WBYTE);
  assign cnt_inc     = us_counter_r + time_us_t'(1);
  assign shift_after = is_write ? {1'b0, shift_data_r[7:1]} : shift_data_r;
  assign new_write   = (in_data.kind == K_WBIT) || (in_data.kind == K_WBYTE);

  always_comb begin
    phase_nxt      = phase_r;
    us_counter_nxt = us_counter_r;
    bits_left_nxt  = bits_left_r;
    shift_data_nxt = shift_data_r;
    active_cmd_nxt = active_cmd_r;
    done           = 1'b0;
    rej            = 1'b0;
    result         = '0;
    case (in_data.kind)
      K_TICK: begin
        if (phase_r != PH_IDLE) begin
          if (cnt_inc < phase_len) begin
            us_counter_nxt = cnt_inc;
          end else begin
            us_counter_nxt = '0;
            case (phase_r)
              PH_RST_LOW: phase_nxt = PH_RST_WAIT;
              PH_RST_WAIT: begin
                shift_data_nxt = {7'd0, in_data.line_level};
                phase_nxt      = PH_RST_TAIL;
              end
              PH_RST_TAIL: begin
                phase_nxt = PH_IDLE;
                done      = 1'b1;
                result    = shift_data_r;
              end
              PH_SLOT_LOW: phase_nxt = is_write ? PH_W1_TAIL : PH_RD_WAIT;
              PH_RD_WAIT: begin
                if (active_cmd_r == K_RBYTE) begin
                  shift_data_nxt = {in_data.line_level, shift_data_r[7:1]};
                end else begin
                  shift_data_nxt = {7'd0, in_data.line_level};
                end
                phase_nxt = PH_RD_TAIL;
              end
              PH_W1_TAIL, PH_W0_LOW, PH_RD_TAIL: begin
                shift_data_nxt = shift_after;
                if (bits_left_r > 4'd1) begin
                  bits_left_nxt = bits_left_r - 4'd1;
                  phase_nxt     = (is_write && !shift_after[0]) ? PH_W0_LOW : PH_SLOT_LOW;
                end else begin
                  bits_left_nxt = '0;
                  phase_nxt     = PH_IDLE;
                  done          = 1'b1;
                  result        = is_write ? 8'd0 : shift_after;
                end
              end
              default: phase_nxt = PH_IDLE;
            endcase
          end
        end
      end
      K_RESET, K_WBIT, K_RBIT, K_WBYTE, K_RBYTE: begin
        if (phase_r != PH_IDLE) begin
          rej = 1'b1;
        end else begin
          active_cmd_nxt = in_data.kind;
          us_counter_nxt = '0;
          case (in_data.kind)
            K_RESET: begin
              bits_left_nxt  = '0;
              shift_data_nxt = '0;
            end
            K_WBIT: begin
              bits_left_nxt  = 4'd1;
              shift_data_nxt = {7'd0, in_data.data_in[0]};
            end
            K_WBYTE: begin
              bits_left_nxt  = BITS_PER_BYTE;
              shift_data_nxt = in_data.data_in;
            end
            K_RBIT: begin
              bits_left_nxt  = 4'd1;
              shift_data_nxt = '0;
            end
            default: begin
              bits_left_nxt  = BITS_PER_BYTE;
              shift_data_nxt = '0;
            end
          endcase
          if (in_data.kind == K_RESET) begin
            phase_nxt = PH_RST_LOW;
          end else if (new_write && !in_data.data_in[0]) begin
            phase_nxt = PH_W0_LOW;
          end else begin
            phase_nxt = PH_SLOT_LOW;
          end
        end
      end
      default: ;
    endcase

    out_nxt.drive_low = (phase_nxt == PH_RST_LOW) || (phase_nxt == PH_SLOT_LOW) ||
                        (phase_nxt == PH_W0_LOW);
    out_nxt.busy_res  = (phase_nxt != PH_IDLE);
    out_nxt.done_res  = done;
    out_nxt.data_out  = done ? result : 8'd0;
    out_nxt.rejected  = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      us_counter_r <= '0;
      bits_left_r  <= '0;
      shift_data_r <= '0;
      active_cmd_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r      <= phase_nxt;
        us_counter_r <= us_counter_nxt;
        bits_left_r  <= bits_left_nxt;
        shift_data_r <= shift_data_nxt;
        active_cmd_r <= active_cmd_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= out_nxt;
    end
  end

  `OWBM_ASSERT_IMP(a_idle_clean, phase_r == PH_IDLE,
                   bits_left_r == '0 && us_counter_r == '0,
                   "idle state not clean")
  `OWBM_ASSERT_IMP(a_done_not_busy, out_valid_r && out_r.done_res,
                   !out_r.busy_res && !out_r.rejected,
                   "completion while busy or rejected")
  `OWBM_ASSERT_NEXT(a_cmd_starts,
                    in_fire && phase_r == PH_IDLE && in_data.kind != K_TICK &&
                    in_data.kind <= K_RBYTE,
                    phase_r != PH_IDLE && out_r.drive_low,
                    "accepted command did not start")
  `OWBM_ASSERT_NEXT(a_reject_holds,
                    in_fire && phase_r != PH_IDLE && in_data.kind != K_TICK &&
                    in_data.kind <= K_RBYTE,
                    $stable(phase_r) && $stable(shift_data_r) && out_r.rejected,
                    "rejected command changed state")

endmodule
